[hw/rtl/dpod_pkg.sv]
package dpod_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int NUM_W   = 23;   // day number of year 16383-12-31 fits
    localparam int CNT_W   = 22;
    localparam int CUM_W   = 9;
    localparam int LEN_W   = 5;

    localparam logic [CNT_W-1:0]   COUNT_MAX = {CNT_W{1'b1}};
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    // x / 25 for x < 4096 as (x * DIV25_MUL) >> DIV25_SHIFT
    localparam int DIV25_MUL   = 5243;
    localparam int DIV25_SHIFT = 17;

    typedef struct packed {
        logic [CNT_W-1:0] overlap_days;
        logic             periods_overlap;
        logic             date_invalid;
    } t_result;

    // days before the first of a month, common year
    function automatic logic [CUM_W-1:0] cum_days(input logic [MONTH_W-1:0] m);
        logic [CUM_W-1:0] c;
        case (m)
            4'd1:    c = 9'd0;
            4'd2:    c = 9'd31;
            4'd3:    c = 9'd59;
            4'd4:    c = 9'd90;
            4'd5:    c = 9'd120;
            4'd6:    c = 9'd151;
            4'd7:    c = 9'd181;
            4'd8:    c = 9'd212;
            4'd9:    c = 9'd243;
            4'd10:   c = 9'd273;
            4'd11:   c = 9'd304;
            4'd12:   c = 9'd334;
            default: c = 9'd0;
        endcase
        return c;
    endfunction

    // month length, common year; zero for a month that does not exist
    function automatic logic [LEN_W-1:0] month_len(input logic [MONTH_W-1:0] m);
        logic [LEN_W-1:0] l;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: l = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    l = 5'd30;
            4'd2:                                       l = 5'd28;
            default:                                    l = 5'd0;
        endcase
        return l;
    endfunction

endpackage

[hw/rtl/dpod_daynum.sv]
module dpod_daynum #(
    parameter int MAX_YEAR = 9999
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [dpod_pkg::YEAR_W-1:0]   i_year,
    input  logic [dpod_pkg::MONTH_W-1:0]  i_month,
    input  logic [dpod_pkg::DAY_W-1:0]    i_day,
    output logic [dpod_pkg::NUM_W-1:0]    o_num,
    output logic                          o_ok
);
    import dpod_pkg::*;

    localparam logic [YEAR_W:0] MaxYear = (YEAR_W+1)'(MAX_YEAR);

    // stage 1: constant products
    logic [YEAR_W-1:0]  n1_p;
    logic [YEAR_W-3:0]  n1_q4p;
    logic [YEAR_W-3:0]  n1_q4y;

    logic [NUM_W-1:0]   r1_mp365;
    logic [24:0]        r1_prod_p;
    logic [24:0]        r1_prod_y;
    logic [YEAR_W-3:0]  r1_q4p;
    logic [YEAR_W-3:0]  r1_q4y;
    logic               r1_y4;
    logic               r1_y_ok;
    logic [MONTH_W-1:0] r1_m;
    logic [DAY_W-1:0]   r1_d;
    logic [CUM_W-1:0]   r1_cum;
    logic [LEN_W-1:0]   r1_len;

    assign n1_p   = i_year - YEAR_W'(1);
    assign n1_q4p = n1_p[YEAR_W-1:2];
    assign n1_q4y = i_year[YEAR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_mp365  <= NUM_W'(n1_p) * NUM_W'(365);
            r1_prod_p <= 25'(n1_q4p) * 25'(DIV25_MUL);
            r1_prod_y <= 25'(n1_q4y) * 25'(DIV25_MUL);
            r1_q4p    <= n1_q4p;
            r1_q4y    <= n1_q4y;
            r1_y4     <= (i_year[1:0] == 2'b00);
            r1_y_ok   <= (i_year != '0) && ((YEAR_W+1)'(i_year) <= MaxYear);
            r1_m      <= i_month;
            r1_d      <= i_day;
            r1_cum    <= cum_days(i_month);
            r1_len    <= month_len(i_month);
        end
    end

    // stage 2: century terms and leap rule
    logic [7:0]         n2_q100p;
    logic [5:0]         n2_q400p;
    logic [7:0]         n2_q100y;
    logic               n2_cent;

    logic [NUM_W-1:0]   r2_a;
    logic [7:0]         r2_b;
    logic               r2_leap;
    logic               r2_y_ok;
    logic [MONTH_W-1:0] r2_m;
    logic [DAY_W-1:0]   r2_d;
    logic [CUM_W-1:0]   r2_cum;
    logic [LEN_W-1:0]   r2_len;

    assign n2_q100p = r1_prod_p[DIV25_SHIFT +: 8];
    assign n2_q400p = n2_q100p[7:2];
    assign n2_q100y = r1_prod_y[DIV25_SHIFT +: 8];
    // year divisible by 100: divisible by 4 and year/4 divisible by 25
    assign n2_cent  = r1_y4 && (r1_q4y == 12'(12'(n2_q100y) * 12'd25));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_a    <= r1_mp365 + NUM_W'(r1_q4p);
            r2_b    <= n2_q100p - 8'(n2_q400p);
            r2_leap <= r1_y4 && (!n2_cent || (n2_q100y[1:0] == 2'b00));
            r2_y_ok <= r1_y_ok;
            r2_m    <= r1_m;
            r2_d    <= r1_d;
            r2_cum  <= r1_cum;
            r2_len  <= r1_len;
        end
    end

    // stage 3: final sum and range check
    logic             n3_leap_day;
    logic             n3_m_ok;
    logic [LEN_W:0]   n3_len;

    assign n3_leap_day = r2_leap && (r2_m > MONTH_FEB);
    assign n3_m_ok     = (r2_m != '0) && (r2_m <= MONTH_DEC);
    assign n3_len      = (LEN_W+1)'(r2_len) + (LEN_W+1)'(r2_leap && (r2_m == MONTH_FEB));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_num <= r2_a - NUM_W'(r2_b) + NUM_W'(r2_cum) + NUM_W'(n3_leap_day)
                     + NUM_W'(r2_d);
            o_ok  <= r2_y_ok && n3_m_ok && (r2_d != '0)
                     && ((LEN_W+1)'(r2_d) <= n3_len);
        end
    end

endmodule

[hw/rtl/date_period_overlap_days_unit.sv]
// Date period overlap, Gregorian calendar.
// Input channel (i_valid / o_stall) carries two periods, each a start and an
// end date as year, month, day. Output channel (o_valid / i_stall) carries
// one result item per input item: the count of days in both periods with
// both ends included, a flag that the periods share a day, and a flag that
// one of the four dates is invalid (count and overlap flag are then zero).
// A reversed period shares no day.
// Throughput: one item per cycle while o_stall is low. Each item passes
// through the three-stage day-number pipe (constant products, century/leap
// terms, final sum), one max/min stage and the output register.
// Reset (i_rst_n low, synchronous) empties the pipe and the output side;
// no configuration exists.
// When the receiver stalls, the output register holds its item and a skid
// register catches the next one leaving the pipe; o_stall then rises, from a
// register, and the whole pipe freezes until the skid drains. Nothing is
// lost or repeated.
module date_period_overlap_days_unit #(
    parameter int MAX_YEAR = 9999
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [dpod_pkg::YEAR_W-1:0]   i_first_start_year,
    input  logic [dpod_pkg::MONTH_W-1:0]  i_first_start_month,
    input  logic [dpod_pkg::DAY_W-1:0]    i_first_start_day,
    input  logic [dpod_pkg::YEAR_W-1:0]   i_first_end_year,
    input  logic [dpod_pkg::MONTH_W-1:0]  i_first_end_month,
    input  logic [dpod_pkg::DAY_W-1:0]    i_first_end_day,
    input  logic [dpod_pkg::YEAR_W-1:0]   i_second_start_year,
    input  logic [dpod_pkg::MONTH_W-1:0]  i_second_start_month,
    input  logic [dpod_pkg::DAY_W-1:0]    i_second_start_day,
    input  logic [dpod_pkg::YEAR_W-1:0]   i_second_end_year,
    input  logic [dpod_pkg::MONTH_W-1:0]  i_second_end_month,
    input  logic [dpod_pkg::DAY_W-1:0]    i_second_end_day,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [dpod_pkg::CNT_W-1:0]    o_overlap_days,
    output logic                          o_periods_overlap,
    output logic                          o_date_invalid
);
    import dpod_pkg::*;

    logic             en;
    logic [3:0]       r_vld;
    logic [NUM_W-1:0] num [4];
    logic [3:0]       ok;

    assign en = !o_stall;

    dpod_daynum #(.MAX_YEAR(MAX_YEAR)) u_fs (
        .i_clk(i_clk), .i_en(en),
        .i_year(i_first_start_year), .i_month(i_first_start_month),
        .i_day(i_first_start_day), .o_num(num[0]), .o_ok(ok[0])
    );
    dpod_daynum #(.MAX_YEAR(MAX_YEAR)) u_fe (
        .i_clk(i_clk), .i_en(en),
        .i_year(i_first_end_year), .i_month(i_first_end_month),
        .i_day(i_first_end_day), .o_num(num[1]), .o_ok(ok[1])
    );
    dpod_daynum #(.MAX_YEAR(MAX_YEAR)) u_ss (
        .i_clk(i_clk), .i_en(en),
        .i_year(i_second_start_year), .i_month(i_second_start_month),
        .i_day(i_second_start_day), .o_num(num[2]), .o_ok(ok[2])
    );
    dpod_daynum #(.MAX_YEAR(MAX_YEAR)) u_se (
        .i_clk(i_clk), .i_en(en),
        .i_year(i_second_end_year), .i_month(i_second_end_month),
        .i_day(i_second_end_day), .o_num(num[3]), .o_ok(ok[3])
    );

    // valid bits alongside the three day-number stages and the max/min stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[2:0], i_valid};
        end
    end

    // stage 4: latest start, earliest end
    logic [NUM_W-1:0] r4_lo;
    logic [NUM_W-1:0] r4_hi;
    logic             r4_bad;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_lo  <= (num[0] > num[2]) ? num[0] : num[2];
            r4_hi  <= (num[1] < num[3]) ? num[1] : num[3];
            r4_bad <= (ok != 4'hF);
        end
    end

    // count, saturated
    logic [NUM_W-1:0] span;
    logic             hit;
    t_result          n_res;

    assign span = r4_hi - r4_lo + NUM_W'(1);
    assign hit  = !r4_bad && (r4_hi >= r4_lo);

    always_comb begin
        n_res.date_invalid    = r4_bad;
        n_res.periods_overlap = hit;
        if (!hit) begin
            n_res.overlap_days = '0;
        end else if (span > NUM_W'(COUNT_MAX)) begin
            n_res.overlap_days = COUNT_MAX;
        end else begin
            n_res.overlap_days = span[CNT_W-1:0];
        end
    end

    // output register plus skid
    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    in_item;

    assign in_item = r_vld[3] && en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || !i_stall) begin
            r_out_valid  <= r_skid_valid || in_item;
            r_skid_valid <= 1'b0;
        end else if (in_item) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || !i_stall) begin
            r_out <= r_skid_valid ? r_skid : n_res;
        end else if (in_item) begin
            r_skid <= n_res;
        end
    end

    assign o_stall           = r_skid_valid;
    assign o_valid           = r_out_valid;
    assign o_overlap_days    = r_out.overlap_days;
    assign o_periods_overlap = r_out.periods_overlap;
    assign o_date_invalid    = r_out.date_invalid;

endmodule

[hw/rtl/dpod_check.sv]
module dpod_check (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_stall,
    input logic                        o_valid,
    input logic [dpod_pkg::CNT_W-1:0]  o_overlap_days,
    input logic                        o_periods_overlap,
    input logic                        o_date_invalid
);
    import dpod_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result item shown right after reset");

    a_overlap_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_periods_overlap == (o_overlap_days != '0)))
        else $error("overlap flag disagrees with day count");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_date_invalid) |-> (o_overlap_days == '0) && !o_periods_overlap)
        else $error("invalid date item carries a nonzero count");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid && $stable(o_overlap_days)
            && $stable(o_periods_overlap) && $stable(o_date_invalid))
        else $error("stalled result item changed");

endmodule

bind date_period_overlap_days_unit dpod_check u_dpod_check (.*);
